[hw/rtl/mts_pkg.sv]
// Shared constants and types for the min-tracking stack.
package mts_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_STACK_DEPTH = 1024;
    localparam int DEF_VALUE_BITS  = 32;

    // Fixed port widths
    localparam int CMD_BITS    = 2;
    localparam int RESULT_BITS = 32;
    localparam int STATUS_BITS = 2;
    localparam int DEPTH_BITS  = 11;

    // Command codes
    localparam logic [CMD_BITS-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_POP  = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_MIN  = 2'd2;
    localparam logic [CMD_BITS-1:0] CMD_NOP  = 2'd3;

    // Status codes
    localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;
    localparam logic [STATUS_BITS-1:0] STATUS_RSVD  = 2'd3;

    // Decoded operation handed from front to back; all clear means no-op
    typedef struct packed {
        logic push;
        logic pop;
        logic min;
    } mts_op_t;

endpackage

[hw/rtl/mts_front.sv]
// Front end: accepts command words, decodes them and queues them for the back end.
module mts_front #(
    parameter int VALUE_BITS = mts_pkg::DEF_VALUE_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [mts_pkg::CMD_BITS-1:0]     s_cmd,
    input  logic signed [mts_pkg::RESULT_BITS-1:0] s_push_value,
    output logic                             q_valid,
    input  logic                             q_pop,
    output mts_pkg::mts_op_t                 q_op,
    output logic [VALUE_BITS-1:0]            q_value
);

    localparam int QUEUE_DEPTH = 2;
    localparam int WIDE_BITS   = mts_pkg::RESULT_BITS + VALUE_BITS;

    mts_pkg::mts_op_t          op_reg [QUEUE_DEPTH];
    logic [VALUE_BITS-1:0]     val_reg [QUEUE_DEPTH];
    logic                      wr_ptr_reg, wr_ptr_next;
    logic                      rd_ptr_reg, rd_ptr_next;
    logic [1:0]                count_reg, count_next;

    mts_pkg::mts_op_t          dec_op;
    logic [WIDE_BITS-1:0]      val_wide;
    logic                      push_en;
    logic                      pop_en;

    // Decode the command word
    always_comb begin
        dec_op = '0;
        case (s_cmd)
            mts_pkg::CMD_PUSH: dec_op.push = 1'b1;
            mts_pkg::CMD_POP:  dec_op.pop  = 1'b1;
            mts_pkg::CMD_MIN:  dec_op.min  = 1'b1;
            default:           dec_op      = '0;
        endcase
    end

    // Take the value as VALUE_BITS bits, zero-filled when wider than the port
    assign val_wide = {{VALUE_BITS{1'b0}}, s_push_value};

    assign s_ready = (count_reg != 2'(QUEUE_DEPTH));
    assign push_en = s_valid && s_ready;
    assign pop_en  = q_pop && (count_reg != 2'd0);

    assign q_valid = (count_reg != 2'd0);
    assign q_op    = op_reg[rd_ptr_reg];
    assign q_value = val_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push_en;
        rd_ptr_next = rd_ptr_reg ^ pop_en;
        count_next  = count_reg + 2'(push_en) - 2'(pop_en);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold queued words
    always_ff @(posedge aclk) begin
        if (push_en) begin
            op_reg[wr_ptr_reg]  <= dec_op;
            val_reg[wr_ptr_reg] <= val_wide[VALUE_BITS-1:0];
        end
    end

endmodule

[hw/rtl/mts_back.sv]
// Back end: stack memory, fill count and result register; one word at a time, read in issue and executed in exec.
module mts_back #(
    parameter int STACK_DEPTH = mts_pkg::DEF_STACK_DEPTH,
    parameter int VALUE_BITS  = mts_pkg::DEF_VALUE_BITS
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   q_valid,
    output logic                                   q_pop,
    input  mts_pkg::mts_op_t                       q_op,
    input  logic [VALUE_BITS-1:0]                  q_value,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [mts_pkg::RESULT_BITS-1:0] m_result_value,
    output logic [mts_pkg::STATUS_BITS-1:0]        m_status,
    output logic [mts_pkg::DEPTH_BITS-1:0]         m_depth_now
);

    localparam int ADDR_BITS = $clog2(STACK_DEPTH);
    localparam int CNT_BITS  = $clog2(STACK_DEPTH + 1);
    localparam int RES_WIDE  = mts_pkg::RESULT_BITS + VALUE_BITS;
    localparam int DEP_WIDE  = mts_pkg::DEPTH_BITS + CNT_BITS;

    localparam logic ST_ISSUE = 1'b0;
    localparam logic ST_EXEC  = 1'b1;

    localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(STACK_DEPTH);

    // Each entry holds {running minimum, value}
    logic [2*VALUE_BITS-1:0]   stack_mem [STACK_DEPTH];
    logic [2*VALUE_BITS-1:0]   rd_data_reg;

    logic                      state_reg, state_next;
    logic [CNT_BITS-1:0]       fill_reg, fill_next;
    mts_pkg::mts_op_t          op_reg;
    logic [VALUE_BITS-1:0]     value_reg;

    logic                      m_valid_reg, m_valid_next;
    logic [mts_pkg::RESULT_BITS-1:0] m_result_reg, m_result_next;
    logic [mts_pkg::STATUS_BITS-1:0] m_status_reg, m_status_next;
    logic [mts_pkg::DEPTH_BITS-1:0]  m_depth_reg, m_depth_next;

    logic                      rd_en;
    logic [ADDR_BITS-1:0]      rd_addr;
    logic                      wr_en;
    logic [VALUE_BITS-1:0]     new_min;
    logic [VALUE_BITS-1:0]     top_val;
    logic [VALUE_BITS-1:0]     top_min;
    logic [VALUE_BITS-1:0]     res;
    logic [RES_WIDE-1:0]       res_wide;
    logic [DEP_WIDE-1:0]       depth_wide;
    logic                      exec_fire;
    logic                      is_empty;
    logic                      is_full;
    logic [CNT_BITS-1:0]       fill_minus;

    assign top_val    = rd_data_reg[VALUE_BITS-1:0];
    assign top_min    = rd_data_reg[2*VALUE_BITS-1:VALUE_BITS];
    assign is_empty   = (fill_reg == '0);
    assign is_full    = (fill_reg == FULL_COUNT);
    assign fill_minus = fill_reg - CNT_BITS'(1);

    // Issue a read of the top entry as the word leaves the queue
    assign q_pop   = (state_reg == ST_ISSUE) && q_valid;
    assign rd_en   = q_pop;
    assign rd_addr = fill_minus[ADDR_BITS-1:0];

    // Execute once the result register is free
    assign exec_fire = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);

    // Running minimum of the new entry and the one below it
    assign new_min = (!is_empty && ($signed(top_min) < $signed(value_reg))) ? top_min
                                                                           : value_reg;

    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        wr_en      = 1'b0;
        res        = '0;
        m_status_next = mts_pkg::STATUS_OK;
        case (state_reg)
            ST_ISSUE: begin
                if (q_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_fire) begin
                    state_next = ST_ISSUE;
                    if (op_reg.push) begin
                        if (is_full) begin
                            m_status_next = mts_pkg::STATUS_FULL;
                        end else begin
                            wr_en     = 1'b1;
                            fill_next = fill_reg + CNT_BITS'(1);
                        end
                    end else if (op_reg.pop) begin
                        if (is_empty) begin
                            m_status_next = mts_pkg::STATUS_EMPTY;
                        end else begin
                            res       = top_val;
                            fill_next = fill_minus;
                        end
                    end else if (op_reg.min) begin
                        if (is_empty) begin
                            m_status_next = mts_pkg::STATUS_EMPTY;
                        end else begin
                            res = top_min;
                        end
                    end
                end
            end
            default: state_next = ST_ISSUE;
        endcase
    end

    // Fit result and depth to the port widths
    assign res_wide      = {{mts_pkg::RESULT_BITS{1'b0}}, res};
    assign m_result_next = res_wide[mts_pkg::RESULT_BITS-1:0];
    assign depth_wide    = {{mts_pkg::DEPTH_BITS{1'b0}}, fill_next};
    assign m_depth_next  = depth_wide[mts_pkg::DEPTH_BITS-1:0];

    always_comb begin
        m_valid_next = m_valid_reg;
        if (exec_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_ISSUE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Latch the word being worked on
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            op_reg    <= q_op;
            value_reg <= q_value;
        end
    end

    // Load the result word
    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            m_result_reg <= m_result_next;
            m_status_reg <= m_status_next;
            m_depth_reg  <= m_depth_next;
        end
    end

    // Stack memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[fill_reg[ADDR_BITS-1:0]] <= {new_min, value_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= stack_mem[rd_addr];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = m_result_reg;
    assign m_status       = m_status_reg;
    assign m_depth_now    = m_depth_reg;

endmodule

[hw/rtl/min_tracking_stack.sv]
// Top level of the min-tracking stack: push, pop and minimum query.
// A command word passes through the command queue, then the word latch and stack read, then the result register.
// The back end takes one word at a time: it reads the top entry, then executes it and loads the result.
// A two-entry command queue lets input keep flowing while a result waits.
// Reset (aresetn low, synchronous) empties the stack and both handshakes;
// memory contents are not cleared and there is no clearing pass.
module min_tracking_stack #(
    parameter int STACK_DEPTH = mts_pkg::DEF_STACK_DEPTH,
    parameter int VALUE_BITS  = mts_pkg::DEF_VALUE_BITS
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [mts_pkg::CMD_BITS-1:0]           s_cmd,
    input  logic signed [mts_pkg::RESULT_BITS-1:0] s_push_value,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [mts_pkg::RESULT_BITS-1:0] m_result_value,
    output logic [mts_pkg::STATUS_BITS-1:0]        m_status,
    output logic [mts_pkg::DEPTH_BITS-1:0]         m_depth_now
);

    logic                  q_valid;
    logic                  q_pop;
    mts_pkg::mts_op_t      q_op;
    logic [VALUE_BITS-1:0] q_value;

    mts_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_push_value (s_push_value),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_op         (q_op),
        .q_value      (q_value)
    );

    mts_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .VALUE_BITS  (VALUE_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_pop          (q_pop),
        .q_op           (q_op),
        .q_value        (q_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_status       (m_status),
        .m_depth_now    (m_depth_now)
    );

endmodule

[hw/rtl/mts_checker.sv]
// Port-level checks for the min-tracking stack, bound to the top level.
module mts_checker #(
    parameter int STACK_DEPTH = mts_pkg::DEF_STACK_DEPTH
) (
    input logic                                   aclk,
    input logic                                   aresetn,
    input logic                                   m_valid,
    input logic                                   m_ready,
    input logic signed [mts_pkg::RESULT_BITS-1:0] m_result_value,
    input logic [mts_pkg::STATUS_BITS-1:0]        m_status,
    input logic [mts_pkg::DEPTH_BITS-1:0]         m_depth_now
);

    localparam int CNT_BITS = $clog2(STACK_DEPTH + 1);
    localparam int DEP_WIDE = mts_pkg::DEPTH_BITS + CNT_BITS;
    localparam logic [DEP_WIDE-1:0] FULL_WIDE = DEP_WIDE'(STACK_DEPTH);
    localparam logic [mts_pkg::DEPTH_BITS-1:0] FULL_DEPTH =
        FULL_WIDE[mts_pkg::DEPTH_BITS-1:0];

    // Reset drops any pending result word
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word valid after reset");

    // Stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_value)
            && $stable(m_status) && $stable(m_depth_now))
        else $error("stalled result word changed");

    // Empty status means nothing held and a zero result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == mts_pkg::STATUS_EMPTY |->
            m_depth_now == '0 && m_result_value == '0)
        else $error("empty status with entries held or nonzero result");

    // Full status only at full depth, zero result, never the reserved code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status != mts_pkg::STATUS_RSVD
            && (m_status != mts_pkg::STATUS_FULL
                || (m_depth_now == FULL_DEPTH && m_result_value == '0)))
        else $error("bad full status");

endmodule

bind min_tracking_stack mts_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_mts_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_result_value (m_result_value),
    .m_status       (m_status),
    .m_depth_now    (m_depth_now)
);
